[sv/hbme_pkg.sv]
// shared types, codes and constants of the heartbeat membership and election unit
package hbme_pkg;

  localparam int ADDR_W     = 32;
  localparam int TIME_W     = 32;
  localparam int ROLE_W     = 2;
  localparam int KIND_W     = 3;
  localparam int SLOT_W     = 3;
  localparam int COUNT_W    = 4;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // request codes
  localparam logic [REQ_W-1:0] REQ_HEARTBEAT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SWEEP     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_EVAL      = 2'd2;

  // peer role codes
  localparam logic [ROLE_W-1:0] ROLE_MASTER = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_SLAVE  = 2'd1;
  localparam logic [ROLE_W-1:0] ROLE_UNDEF  = 2'd2;

  // own role codes
  localparam logic SELF_MASTER = 1'b0;
  localparam logic SELF_SLAVE  = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_REFRESHED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_IGNORED   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SWEEP_END = 3'd5;
  localparam logic [KIND_W-1:0] KIND_EVALUATED = 3'd6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ROLE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_TIMEOUT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONELY_TIMEOUT = 2'd3;

  localparam logic [TIME_W-1:0] PEER_TIMEOUT_RST   = 32'd3000000;
  localparam logic [TIME_W-1:0] LONELY_TIMEOUT_RST = 32'd10000000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [ADDR_W-1:0] peer_address;
    logic [ROLE_W-1:0] peer_role;
    logic [TIME_W-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  result_kind;
    logic [SLOT_W-1:0]  slot_index;
    logic [ADDR_W-1:0]  node_address;
    logic               own_role;
    logic               announce;
    logic               single_mode;
    logic [COUNT_W-1:0] alive_count;
    logic [COUNT_W-1:0] leader_count;
    logic [COUNT_W-1:0] follower_count;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [ROLE_W-1:0] role;
    logic [TIME_W-1:0] seen_time;
  } entry_t;

  typedef struct packed {
    logic key_equal;
    logic key_less;
    logic elapsed_over;
  } cmp_result_t;

endpackage

[sv/hbme_ram.sv]
// generic simple dual port ram with registered read
module hbme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/hbme_cmp_unit.sv]
// shared key compare and wrap-around elapsed time compare
module hbme_cmp_unit (
  input  logic [hbme_pkg::ADDR_W-1:0] key_a,
  input  logic [hbme_pkg::ADDR_W-1:0] key_b,
  input  logic [hbme_pkg::TIME_W-1:0] now_time,
  input  logic [hbme_pkg::TIME_W-1:0] base_time,
  input  logic [hbme_pkg::TIME_W-1:0] limit,
  output hbme_pkg::cmp_result_t       res
);

  logic [hbme_pkg::TIME_W-1:0] elapsed;

  // modulo 2^32 difference
  assign elapsed          = now_time - base_time;
  assign res.elapsed_over = (elapsed > limit);
  assign res.key_equal    = (key_a == key_b);
  assign res.key_less     = (key_a < key_b);

endmodule

[sv/heartbeat_membership_election_unit.sv]
// top level: peer table, scan sequencer, election and result register
//
// Peer table of NODE_SLOTS entries (address, role, last seen time) in a ram
// with one read port, liveness in flip-flops cleared at reset, so no clearing
// pass is needed. A heartbeat, sweep or evaluation is scanned one slot a
// cycle (held while a result waits) through the table read port and the single
// shared compare unit, then finishes in a closing state. A heartbeat that
// refreshes the live entry in slot k ends at that slot; an ignored heartbeat
// or an unknown request skips the scan and goes straight to the closing state.
// Each result waits in the sequencer until the result register is free.
// The input side is ready in idle, never during reset, even while a result
// still sits in the output register.
// Configuration writes are taken at any edge out of reset with cfg_we high and are
// meant for idle.
module heartbeat_membership_election_unit #(
  parameter int NODE_SLOTS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [hbme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hbme_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  hbme_pkg::in_item_t             item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output hbme_pkg::out_item_t            result
);

  localparam int IDX_W = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int CNT_W = $clog2(NODE_SLOTS + 1);
  localparam int SW    = hbme_pkg::SLOT_W;
  localparam int CW    = hbme_pkg::COUNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_SLOTS - 1);

  hbme_pkg::state_t state, state_next;

  // configuration
  logic [hbme_pkg::ADDR_W-1:0] own_address;
  logic [hbme_pkg::TIME_W-1:0] peer_timeout;
  logic [hbme_pkg::TIME_W-1:0] lonely_timeout;

  // election state
  logic                        self_role;
  logic                        single_latched;
  logic [hbme_pkg::TIME_W-1:0] contact_time;
  logic                        contact_valid;

  // peer liveness, one flop per slot
  logic [NODE_SLOTS-1:0] live;

  // current request and scan registers
  hbme_pkg::in_item_t cur;
  logic               skip;
  logic [IDX_W-1:0]   idx, idx_next;
  logic               free_found;
  logic [IDX_W-1:0]   free_slot;
  logic [CNT_W-1:0]   alive_cnt, master_cnt, slave_cnt;
  logic               highest;

  // table port
  hbme_pkg::entry_t rd_data, wr_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;

  // compare unit
  logic [hbme_pkg::ADDR_W-1:0] key_a, key_b;
  logic [hbme_pkg::TIME_W-1:0] base_time, limit;
  hbme_pkg::cmp_result_t       cmp;

  // sequencer signals
  logic                accept;
  logic                accept_skip;
  logic                slot_live;
  logic                last_slot;
  logic                out_free;
  logic                emit;
  hbme_pkg::out_item_t emit_item;
  logic                advance;
  logic                finish;
  logic                set_live;
  logic                clr_live;
  logic                role_new;
  logic                changed;
  logic                single_new;
  logic [hbme_pkg::TIME_W-1:0] contact_base;
  logic [hbme_pkg::ROLE_W-1:0] role_clamped;

  assign item_ready = (state == hbme_pkg::ST_IDLE) && !rst;
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;
  assign slot_live  = live[idx];
  assign last_slot  = (idx == LAST_IDX);

  // undefined role codes are kept as undefined
  assign role_clamped = (item.peer_role > hbme_pkg::ROLE_UNDEF) ? hbme_pkg::ROLE_UNDEF
                                                                  : item.peer_role;

  // first contact loads the reference time before the lonely check
  assign contact_base = contact_valid ? contact_time : cur.now_time;

  // own-address and single-mode filter, unknown request codes skip the scan
  always_comb begin
    if (item.req_type == hbme_pkg::REQ_HEARTBEAT) begin
      accept_skip = single_latched || cmp.key_equal;
    end else begin
      accept_skip = !((item.req_type == hbme_pkg::REQ_SWEEP) ||
                      (item.req_type == hbme_pkg::REQ_EVAL));
    end
  end

  // operand selection for the shared compare unit
  always_comb begin
    if (state == hbme_pkg::ST_IDLE) begin
      key_a = own_address;
      key_b = item.peer_address;
    end else begin
      key_a = (cur.req_type == hbme_pkg::REQ_EVAL) ? own_address : cur.peer_address;
      key_b = rd_data.address;
    end
    if (state == hbme_pkg::ST_FINAL) begin
      base_time = contact_base;
      limit     = lonely_timeout;
    end else begin
      base_time = rd_data.seen_time;
      limit     = peer_timeout;
    end
  end

  hbme_cmp_unit u_cmp (
    .key_a     (key_a),
    .key_b     (key_b),
    .now_time  (cur.now_time),
    .base_time (base_time),
    .limit     (limit),
    .res       (cmp)
  );

  // read address runs one step ahead so rd_data always holds slot idx
  hbme_ram #(
    .WIDTH ($bits(hbme_pkg::entry_t)),
    .DEPTH (NODE_SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx_next),
    .rd_data (rd_data)
  );

  assign wr_data.address   = cur.peer_address;
  assign wr_data.role      = cur.peer_role;
  assign wr_data.seen_time = cur.now_time;

  // election outcome, taken in the closing cycle of an evaluation
  always_comb begin
    role_new = self_role;
    changed  = 1'b0;
    if (master_cnt == '0) begin
      if ((self_role == hbme_pkg::SELF_SLAVE) && highest) begin
        role_new = hbme_pkg::SELF_MASTER;
        changed  = 1'b1;
      end
    end else if (self_role == hbme_pkg::SELF_MASTER) begin
      role_new = hbme_pkg::SELF_SLAVE;
      changed  = 1'b1;
    end
    single_new = single_latched | ((alive_cnt == '0) & cmp.elapsed_over);
  end

  // sequencer outputs
  always_comb begin
    emit                  = 1'b0;
    emit_item             = '0;
    emit_item.own_role    = self_role;
    emit_item.single_mode = single_latched;
    emit_item.last        = 1'b1;
    wr_en                 = 1'b0;
    wr_addr               = idx;
    advance               = 1'b0;
    finish                = 1'b0;
    set_live              = 1'b0;
    clr_live              = 1'b0;
    unique case (state)
      hbme_pkg::ST_IDLE: begin
        advance = 1'b0;
      end
      hbme_pkg::ST_SCAN: begin
        unique case (cur.req_type)
          hbme_pkg::REQ_HEARTBEAT: begin
            if (slot_live && cmp.key_equal) begin
              // live entry of the sender: refresh in place and stop
              emit                   = 1'b1;
              emit_item.result_kind  = hbme_pkg::KIND_REFRESHED;
              emit_item.slot_index   = SW'(idx);
              emit_item.node_address = cur.peer_address;
              wr_en                  = out_free;
              advance                = out_free;
              finish                 = 1'b1;
            end else begin
              advance = 1'b1;
            end
          end
          hbme_pkg::REQ_SWEEP: begin
            if (slot_live && cmp.elapsed_over) begin
              emit                   = 1'b1;
              emit_item.result_kind  = hbme_pkg::KIND_EXPIRED;
              emit_item.slot_index   = SW'(idx);
              emit_item.node_address = rd_data.address;
              emit_item.last         = 1'b0;
              advance                = out_free;
              clr_live               = out_free;
            end else begin
              advance = 1'b1;
            end
          end
          default: begin
            advance = 1'b1;
          end
        endcase
      end
      hbme_pkg::ST_FINAL: begin
        emit    = 1'b1;
        advance = out_free;
        if (skip) begin
          emit_item.result_kind = hbme_pkg::KIND_IGNORED;
        end else begin
          unique case (cur.req_type)
            hbme_pkg::REQ_HEARTBEAT: begin
              if (free_found) begin
                emit_item.result_kind  = hbme_pkg::KIND_ADDED;
                emit_item.slot_index   = SW'(free_slot);
                emit_item.node_address = cur.peer_address;
                wr_en                  = out_free;
                wr_addr                = free_slot;
                set_live               = out_free;
              end else begin
                emit_item.result_kind = hbme_pkg::KIND_FULL;
              end
            end
            hbme_pkg::REQ_SWEEP: begin
              emit_item.result_kind = hbme_pkg::KIND_SWEEP_END;
            end
            default: begin
              emit_item.result_kind    = hbme_pkg::KIND_EVALUATED;
              emit_item.own_role       = role_new;
              emit_item.announce       = changed;
              emit_item.single_mode    = single_new;
              emit_item.alive_count    = CW'(alive_cnt);
              emit_item.leader_count   = CW'(master_cnt);
              emit_item.follower_count = CW'(slave_cnt);
            end
          endcase
        end
      end
      default: begin
        advance = 1'b0;
      end
    endcase
  end

  // slot counter, held while a result waits
  always_comb begin
    idx_next = idx;
    if (state == hbme_pkg::ST_IDLE) begin
      idx_next = '0;
    end else if ((state == hbme_pkg::ST_SCAN) && advance && !last_slot && !finish) begin
      idx_next = idx + 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      hbme_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = accept_skip ? hbme_pkg::ST_FINAL : hbme_pkg::ST_SCAN;
        end
      end
      hbme_pkg::ST_SCAN: begin
        if (advance) begin
          if (finish) begin
            state_next = hbme_pkg::ST_IDLE;
          end else if (last_slot) begin
            state_next = hbme_pkg::ST_FINAL;
          end
        end
      end
      hbme_pkg::ST_FINAL: begin
        if (advance) begin
          state_next = hbme_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hbme_pkg::ST_IDLE;
      end
    endcase
  end

  // control state, configuration and election registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= hbme_pkg::ST_IDLE;
      idx            <= '0;
      live           <= '0;
      result_valid   <= 1'b0;
      own_address    <= '0;
      peer_timeout   <= hbme_pkg::PEER_TIMEOUT_RST;
      lonely_timeout <= hbme_pkg::LONELY_TIMEOUT_RST;
      self_role      <= hbme_pkg::SELF_SLAVE;
      single_latched <= 1'b0;
      contact_time   <= '0;
      contact_valid  <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;

      if (set_live) begin
        live[free_slot] <= 1'b1;
      end
      if (clr_live) begin
        live[idx] <= 1'b0;
      end

      if (emit && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      // evaluation closes: role, lonely latch and contact time
      if ((state == hbme_pkg::ST_FINAL) && advance && !skip &&
          (cur.req_type == hbme_pkg::REQ_EVAL)) begin
        self_role      <= role_new;
        single_latched <= single_new;
        contact_valid  <= 1'b1;
        contact_time   <= (alive_cnt == '0) ? contact_base : cur.now_time;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          hbme_pkg::CFG_OWN_ADDRESS:    own_address    <= cfg_data;
          hbme_pkg::CFG_INITIAL_ROLE:   self_role      <= cfg_data[0];
          hbme_pkg::CFG_PEER_TIMEOUT:   peer_timeout   <= cfg_data;
          hbme_pkg::CFG_LONELY_TIMEOUT: lonely_timeout <= cfg_data;
        endcase
      end
    end
  end

  // request payload and scan accumulators
  always_ff @(posedge clk) begin
    if (emit && out_free) begin
      result <= emit_item;
    end
    if (accept) begin
      cur.req_type     <= item.req_type;
      cur.peer_address <= item.peer_address;
      cur.peer_role    <= role_clamped;
      cur.now_time     <= item.now_time;
      skip             <= accept_skip;
      free_found       <= 1'b0;
      free_slot        <= '0;
      alive_cnt        <= '0;
      master_cnt       <= '0;
      slave_cnt        <= '0;
      highest          <= 1'b1;
    end else if (state == hbme_pkg::ST_SCAN) begin
      // lowest dead slot for a new peer
      if ((cur.req_type == hbme_pkg::REQ_HEARTBEAT) && !slot_live && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= idx;
      end
      if ((cur.req_type == hbme_pkg::REQ_EVAL) && slot_live) begin
        alive_cnt <= alive_cnt + 1'b1;
        if (rd_data.role == hbme_pkg::ROLE_SLAVE) begin
          slave_cnt <= slave_cnt + 1'b1;
        end else if (rd_data.role == hbme_pkg::ROLE_MASTER) begin
          master_cnt <= master_cnt + 1'b1;
        end
        if (cmp.key_less) begin
          highest <= 1'b0;
        end
      end
    end
  end

endmodule

[sv/hbme_checker.sv]
// port level checks of the heartbeat membership and election unit, with bind
module hbme_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_ready,
  input logic                result_valid,
  input logic                result_ready,
  input hbme_pkg::out_item_t result
);

  // a waiting result holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // one item at a time
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input ready right after a transfer");

  // only expiries are followed by more results of the same item
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.last == (result.result_kind != hbme_pkg::KIND_EXPIRED)))
    else $error("last flag does not match result kind");

  // counts and announce belong to evaluations only
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.result_kind != hbme_pkg::KIND_EVALUATED) |->
      !result.announce && (result.alive_count == '0) &&
      (result.leader_count == '0) && (result.follower_count == '0))
    else $error("evaluation fields on a non evaluation result");

  // counts by role never exceed live peers
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.result_kind == hbme_pkg::KIND_EVALUATED) |->
      ({1'b0, result.leader_count} + {1'b0, result.follower_count} <=
       {1'b0, result.alive_count}))
    else $error("role counts exceed live count");

endmodule

bind heartbeat_membership_election_unit hbme_checker u_hbme_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
